// ===== rtl/pal_pkg.sv =====
// Shared types and constants for the positional array list unit.
package pal_pkg;

   localparam int PAL_CAPACITY_DEF = 64;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_AMEND  = 2'd3
   } pal_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_POS   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } pal_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } pal_state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } pal_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] found_position;
      logic [6:0] list_length;
   } pal_rsp_type;

endpackage

// ===== rtl/pal_mem.sv =====
// Entry store: one write port and one read port with registered read data.
module pal_mem
   import pal_pkg::*;
#(
   parameter int DEPTH = PAL_CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pal_seq.sv =====
// Command sequencer: checks positions, streams shifts and scans through the entry store.
module pal_seq
   import pal_pkg::*;
#(
   parameter int CAPACITY = PAL_CAPACITY_DEF,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  pal_req_type   req_data,
   output logic          busy,
   input  logic          out_ready,
   output logic          res_valid,
   output pal_rsp_type   res_data,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [31:0]   mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic [31:0]   mem_rdata
);

   // Wide enough for count, position and their sums without wrap.
   localparam int XW = ((CW > 7) ? CW : 7) + 1;

   pal_state_type  state_ff, state_in;
   pal_cmd_type    cmd_ff, cmd_in;
   pal_status_type status_ff, status_in;
   logic [6:0]     found_ff, found_in;
   logic [AW-1:0]  lo_ff, lo_in;
   logic [31:0]    val_ff, val_in;
   logic [31:0]    nval_ff, nval_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  remaining_ff, remaining_in;
   logic [AW-1:0]  nxt_ff, nxt_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [AW-1:0]  rd_addr_ff, rd_addr_in;

   logic [XW-1:0]  pos_x;
   logic [XW-1:0]  cnt_x;
   logic [XW-1:0]  hit_x;
   logic           issue;

   assign pos_x = XW'(req_data.position);
   assign cnt_x = XW'(count_ff);
   assign hit_x = XW'(rd_addr_ff) + XW'(1);
   assign issue = (remaining_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
      cmd_ff       <= cmd_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      lo_ff        <= lo_in;
      val_ff       <= val_in;
      nval_ff      <= nval_in;
      remaining_ff <= remaining_in;
      nxt_ff       <= nxt_in;
      rd_addr_ff   <= rd_addr_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      lo_in        = lo_ff;
      val_in       = val_ff;
      nval_in      = nval_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      nxt_in       = nxt_ff;
      rd_pend_in   = 1'b0;
      rd_addr_in   = rd_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = nxt_ff;
      busy         = (state_ff != ST_IDLE);
      res_valid    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = pal_cmd_type'(req_data.command);
               val_in    = req_data.value;
               nval_in   = req_data.new_value;
               status_in = STATUS_OK;
               found_in  = '0;
               state_in  = ST_RUN;
               case (pal_cmd_type'(req_data.command))
                  CMD_INSERT: begin
                     // Position check comes before the full check.
                     if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                        status_in = STATUS_BAD_POS;
                        state_in  = ST_DONE;
                     end else if (cnt_x == XW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        lo_in        = AW'(pos_x - XW'(1));
                        remaining_in = CW'(cnt_x - pos_x + XW'(1));
                        nxt_in       = AW'(cnt_x - XW'(1));
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = STATUS_BAD_POS;
                        state_in  = ST_DONE;
                     end else begin
                        lo_in        = AW'(pos_x - XW'(1));
                        remaining_in = CW'(cnt_x - pos_x);
                        nxt_in       = AW'(pos_x);
                     end
                  end
                  default: begin
                     remaining_in = count_ff;
                     nxt_in       = '0;
                  end
               endcase
            end
         end

         ST_RUN: begin
            rd_pend_in = issue;
            rd_addr_in = nxt_ff;
            if (issue) begin
               remaining_in = remaining_ff - CW'(1);
               if (cmd_ff == CMD_INSERT) begin
                  nxt_in = nxt_ff - AW'(1);
               end else begin
                  nxt_in = nxt_ff + AW'(1);
               end
            end
            case (cmd_ff)
               CMD_INSERT: begin
                  if (rd_pend_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_addr_ff + AW'(1);
                     mem_wdata = mem_rdata;
                  end else if (!issue) begin
                     mem_we    = 1'b1;
                     mem_waddr = lo_ff;
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                     state_in  = ST_DONE;
                  end
               end
               CMD_DELETE: begin
                  if (rd_pend_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_addr_ff - AW'(1);
                     mem_wdata = mem_rdata;
                  end else if (!issue) begin
                     count_in = count_ff - CW'(1);
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  if (rd_pend_ff && mem_rdata == val_ff) begin
                     if (cmd_ff == CMD_AMEND) begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_addr_ff;
                        mem_wdata = nval_ff;
                     end else begin
                        found_in = hit_x[6:0];
                     end
                     state_in = ST_DONE;
                  end else if (!rd_pend_ff && !issue) begin
                     status_in = STATUS_NOT_FOUND;
                     state_in  = ST_DONE;
                  end
               end
            endcase
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_data.status         = status_ff;
   assign res_data.found_position = found_ff;
   assign res_data.list_length    = cnt_x[6:0];

endmodule

// ===== rtl/positional_array_list_unit.sv =====
// Top level of the positional array list unit: sequencer, entry store and result register.
// Throughput: one command at a time; the next is taken only after the previous result has
// entered the result register, and the entry store's one read and one write port move or
// compare one entry per cycle.
// Reset (synchronous, active high) empties the list; entries are not cleared and need none.
module positional_array_list_unit
   import pal_pkg::*;
#(
   parameter int CAPACITY = PAL_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pal_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pal_rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic          busy;
   logic          res_valid;
   pal_rsp_type   res_data;
   logic          out_ready;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   pal_rsp_type   rsp_data_ff, rsp_data_in;

   // The sequencer takes a new transfer whenever it is idle, even while the
   // previous result still sits in the output register waiting to be taken.
   assign req_stall = busy;

   pal_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .busy      (busy),
      .out_ready (out_ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Entry store: a shift writes each entry that it read into the neighbouring slot
   // while later reads go on, so the two ports never touch the same entry at once.
   pal_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Output register: it can take a new result when empty or when its
   // current result leaves in this cycle.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
